### hw/rtl/pse_pkg.sv
// shared types and constants for the postfix stack evaluator
// depends on nothing; pse_if, the evaluator and the divider refer to it by scoped names
package pse_pkg;

   localparam int DATA_W = 32;
   localparam int CMD_W  = 3;
   localparam int STAT_W = 2;

   // token kinds
   localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd1;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_DIVZERO   = 2'd3;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_DIVW = 4'b0100,
      S_FIN  = 4'b1000
   } state_type;

   // divider request and answer
   typedef struct packed {
      logic                     start;
      logic signed [DATA_W-1:0] dividend;
      logic signed [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage

### hw/rtl/pse_if.sv
// token and result channels of the postfix stack evaluator
// depends on pse_pkg for field widths
interface pse_req_if;
   logic                              valid;
   logic                              ready;
   logic [pse_pkg::CMD_W-1:0]         cmd;
   logic signed [pse_pkg::DATA_W-1:0] number;
   logic                              last_token;

   modport source(output valid, cmd, number, last_token, input ready);
   modport sink(input valid, cmd, number, last_token, output ready);
endinterface

interface pse_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [pse_pkg::DATA_W-1:0] value;
   logic [pse_pkg::STAT_W-1:0]        status;

   modport source(output valid, value, status, input ready);
   modport sink(input valid, value, status, output ready);
endinterface

### hw/rtl/postfix_stack_evaluator_unit.sv
// postfix (reverse polish) integer expression evaluator
// depends on pse_pkg, pse_if, pse_ram and pse_divider
//
// Tokens arrive on req_if (cmd, number, last_token) by valid/ready transfer.
// A number is pushed; an operator pops two entries and pushes second-from-top op top;
// add, subtract and multiply wrap to 32 bits, divide truncates toward zero.
// The token marked last produces one result on rsp_if: top of stack and a
// status (ok, underflow, overflow, divide by zero), then the stack and the
// sticky error are cleared. The first error of an expression is kept and
// later tokens are ignored until the last one.
// A push, undefined or error-ignored token is handled in the idle step; add,
// subtract or multiply take a ram read of the second entry, then the alu; divide
// takes a ram read, a divider start, the radix-2 divider steps and its done.
// A last token then loads the output register in the finish step.
// The top of stack lives in a register; the entries below it live in a
// one-read one-write ram with a registered read, so reads and writes to the
// same entry never fall in the same cycle.
// Reset (synchronous) empties the stack and drops any pending result; no
// ram clearing pass is needed. A stalled result holds in the output
// register while further non-final tokens are still taken; a final token
// waits in the finish step until the output register is free.
module postfix_stack_evaluator_unit #(
   parameter int STACK_DEPTH = 16
) (
   input logic            clock,
   input logic            reset,
   pse_req_if.sink        req_if,
   pse_rsp_if.source      rsp_if
);

   localparam int W  = pse_pkg::DATA_W;
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   pse_pkg::state_type          state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [pse_pkg::STAT_W-1:0]  err_ff, err_in;
   logic [W-1:0]                tos_ff, tos_in;
   logic [pse_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic                        last_ff, last_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]                value_ff, value_in;
   logic [pse_pkg::STAT_W-1:0]  status_ff, status_in;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [W-1:0]                rd_data;
   logic [CW-1:0]               count_m1;
   logic [CW-1:0]               count_m2;
   logic [W-1:0]                alu_out;
   logic                        out_free;
   pse_pkg::div_req_type        div_req;
   pse_pkg::div_rsp_type        div_rsp;
   pse_pkg::state_type          after_op;

   // stack storage below the top entry
   pse_ram #(
      .WIDTH (W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (tos_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // iterative divider for the divide token
   pse_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign count_m1 = count_ff - CW'(1);
   assign count_m2 = count_ff - CW'(2);
   assign wr_addr  = count_m1[AW-1:0];
   assign rd_addr  = count_m2[AW-1:0];
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign after_op = last_ff ? pse_pkg::S_FIN : pse_pkg::S_IDLE;

   // alu for add, subtract and multiply; second entry from ram, top from register
   always_comb begin
      unique case (cmd_ff)
         pse_pkg::CMD_ADD: alu_out = rd_data + tos_ff;
         pse_pkg::CMD_SUB: alu_out = rd_data - tos_ff;
         pse_pkg::CMD_MUL: alu_out = rd_data * tos_ff;
         default:          alu_out = rd_data;
      endcase
   end

   // token sequencer
   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      err_in           = err_ff;
      tos_in           = tos_ff;
      cmd_in           = cmd_ff;
      last_in          = last_ff;
      value_in         = value_ff;
      status_in        = status_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_if.ready;
      wr_en            = 1'b0;
      rd_en            = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = rd_data;
      div_req.divisor  = tos_ff;

      unique case (state_ff)
         pse_pkg::S_IDLE: begin
            if (req_if.valid) begin
               cmd_in   = req_if.cmd;
               last_in  = req_if.last_token;
               state_in = req_if.last_token ? pse_pkg::S_FIN : pse_pkg::S_IDLE;
               if (err_ff == pse_pkg::STAT_OK) begin
                  priority if (req_if.cmd == pse_pkg::CMD_PUSH) begin
                     if (count_ff == CW'(STACK_DEPTH)) begin
                        err_in = pse_pkg::STAT_OVERFLOW;
                     end else begin
                        // spill old top into ram, new number becomes top
                        wr_en    = (count_ff != '0);
                        tos_in   = req_if.number;
                        count_in = count_ff + CW'(1);
                     end
                  end else if (req_if.cmd > pse_pkg::CMD_DIV) begin
                     // undefined token kind leaves the stack alone
                  end else if (count_ff < CW'(2)) begin
                     err_in = pse_pkg::STAT_UNDERFLOW;
                  end else if (req_if.cmd == pse_pkg::CMD_DIV && tos_ff == '0) begin
                     err_in = pse_pkg::STAT_DIVZERO;
                  end else begin
                     // fetch second entry for the operator
                     rd_en    = 1'b1;
                     state_in = pse_pkg::S_EXEC;
                  end
               end
            end
         end
         pse_pkg::S_EXEC: begin
            if (cmd_ff == pse_pkg::CMD_DIV) begin
               div_req.start = 1'b1;
               state_in      = pse_pkg::S_DIVW;
            end else begin
               tos_in   = alu_out;
               count_in = count_m1;
               state_in = after_op;
            end
         end
         pse_pkg::S_DIVW: begin
            if (div_rsp.done) begin
               tos_in   = div_rsp.quotient;
               count_in = count_m1;
               state_in = after_op;
            end
         end
         pse_pkg::S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (err_ff != pse_pkg::STAT_OK) begin
                  value_in  = '0;
                  status_in = err_ff;
               end else if (count_ff == '0) begin
                  value_in  = '0;
                  status_in = pse_pkg::STAT_UNDERFLOW;
               end else begin
                  value_in  = tos_ff;
                  status_in = pse_pkg::STAT_OK;
               end
               count_in = '0;
               err_in   = pse_pkg::STAT_OK;
               state_in = pse_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pse_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pse_pkg::S_IDLE;
         count_ff     <= '0;
         err_ff       <= pse_pkg::STAT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tos_ff    <= tos_in;
      cmd_ff    <= cmd_in;
      last_ff   <= last_in;
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   assign req_if.ready  = (state_ff == pse_pkg::S_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.value  = value_ff;
   assign rsp_if.status = status_ff;

   // a new result only comes out of the finish step
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(state_ff == pse_pkg::S_FIN))
      else $error("result appeared outside the finish step");

   // stack depth never exceeds its bound
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   // divider answers only while the sequencer waits for it
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == pse_pkg::S_DIVW)
      else $error("divider done outside the divide wait");

   // finishing an expression empties the stack and clears the error
   a_fin_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pse_pkg::S_FIN && out_free)
      |=> (count_ff == '0 && err_ff == pse_pkg::STAT_OK))
      else $error("expression end did not clear the stack");

endmodule

### hw/rtl/pse_ram.sv
// generic single write port, single read port ram with registered read
// depends on nothing
module pse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/pse_divider.sv
// signed 32-bit restoring divider, one quotient bit per cycle, truncates toward zero
// depends on pse_pkg for the request and answer structs
module pse_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  pse_pkg::div_req_type div_req,
   output pse_pkg::div_rsp_type div_rsp
);

   localparam int W  = pse_pkg::DATA_W;
   localparam int CW = $clog2(W);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [W:0]    shifted;
   logic [W:0]    trial;

   // one shift-subtract step per cycle on magnitudes
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend[W-1] ? -div_req.dividend : div_req.dividend;
         dsr_in  = div_req.divisor[W-1] ? -div_req.divisor : div_req.divisor;
         neg_in  = div_req.dividend[W-1] ^ div_req.divisor[W-1];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   // sign fixup; most negative over minus one wraps naturally
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? -quo_ff : quo_ff;

endmodule

### sim/tb_postfix_stack_evaluator_unit.sv
// self-checking testbench for postfix_stack_evaluator_unit
// directed token table, then random rpn streams; depends on pse_pkg, pse_if and the rtl
module tb_postfix_stack_evaluator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_W = pse_pkg::DATA_W;
   localparam int CMD_W  = pse_pkg::CMD_W;
   localparam int STAT_W = pse_pkg::STAT_W;

   localparam int STACK_DEPTH   = 16;
   localparam int RANDOM_TOKENS = 800;
   localparam int LONG_HOLD     = 300;
   localparam int DRAIN_CYCLES  = 80;
   localparam int RUN_LIMIT_NS  = 1_000_000;

   // token kinds the block leaves alone
   localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

   localparam logic [DATA_W-1:0] INT_MAX   = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] INT_MIN   = 32'h8000_0000;
   localparam logic [DATA_W-1:0] MINUS_ONE = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [STAT_W-1:0] status;
   } answer_type;

   // one directed row; pinned rows carry an answer typed in by hand
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] number;
      logic              last;
      logic [4:0]        reps;
      logic              pinned;
      logic [DATA_W-1:0] value;
      logic [STAT_W-1:0] status;
   } token_row_type;

   localparam int N_ROWS = 38;
   localparam token_row_type DIRECTED_ROWS [N_ROWS] = '{
      // single pushes and empty-stack endings
      '{pse_pkg::CMD_PUSH, 32'd0,     1'b1, 5'd1,  1'b1, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_PUSH, INT_MAX,   1'b1, 5'd1,  1'b1, INT_MAX, pse_pkg::STAT_OK},
      '{pse_pkg::CMD_PUSH, INT_MIN,   1'b1, 5'd1,  1'b1, INT_MIN, pse_pkg::STAT_OK},
      '{pse_pkg::CMD_ADD,  32'd0,     1'b1, 5'd1,  1'b1, 32'd0,   pse_pkg::STAT_UNDERFLOW},
      '{CMD_UNDEF_HI,      32'h1234,  1'b1, 5'd1,  1'b1, 32'd0,   pse_pkg::STAT_UNDERFLOW},
      // add wraps past the top
      '{pse_pkg::CMD_PUSH, INT_MAX,   1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_PUSH, 32'd1,     1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_ADD,  32'd0,     1'b1, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      // most negative over minus one
      '{pse_pkg::CMD_PUSH, INT_MIN,   1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_PUSH, MINUS_ONE, 1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_DIV,  32'd0,     1'b1, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      // divide by zero, later tokens ignored
      '{pse_pkg::CMD_PUSH, 32'd7,     1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_PUSH, 32'd0,     1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_DIV,  32'd0,     1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_PUSH, 32'd3,     1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_SUB,  32'd0,     1'b1, 5'd1,  1'b1, 32'd0,   pse_pkg::STAT_DIVZERO},
      // truncation toward zero, undefined kind in between
      '{pse_pkg::CMD_PUSH, -32'sd7,   1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_PUSH, 32'd2,     1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{CMD_UNDEF_LO,      32'd123,   1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_DIV,  32'd0,     1'b1, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      // subtract with a number field that must be ignored, then multiply
      '{pse_pkg::CMD_PUSH, 32'd6,     1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_PUSH, 32'd5,     1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_SUB,  MINUS_ONE, 1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_PUSH, 32'd9,     1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_MUL,  32'd0,     1'b1, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      // operator with one entry
      '{pse_pkg::CMD_PUSH, 32'd4,     1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_MUL,  32'd0,     1'b1, 5'd1,  1'b1, 32'd0,   pse_pkg::STAT_UNDERFLOW},
      // two entries left at the end
      '{pse_pkg::CMD_PUSH, 32'd11,    1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_PUSH, 32'd12,    1'b1, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      // fill the stack, then push once more
      '{pse_pkg::CMD_PUSH, 32'd1,     1'b0, 5'd16, 1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_PUSH, 32'd2,     1'b1, 5'd1,  1'b1, 32'd0,   pse_pkg::STAT_OVERFLOW},
      '{pse_pkg::CMD_PUSH, 32'd5,     1'b1, 5'd1,  1'b1, 32'd5,   pse_pkg::STAT_OK},
      // multiply and subtract at the extremes
      '{pse_pkg::CMD_PUSH, INT_MAX,   1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_PUSH, INT_MAX,   1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_MUL,  32'd0,     1'b1, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_PUSH, INT_MIN,   1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_PUSH, 32'd1,     1'b0, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK},
      '{pse_pkg::CMD_SUB,  32'd0,     1'b1, 5'd1,  1'b0, 32'd0,   pse_pkg::STAT_OK}
   };

   logic clock;
   logic reset;

   pse_req_if req_bus ();
   pse_rsp_if rsp_bus ();

   postfix_stack_evaluator_unit #(
      .STACK_DEPTH(STACK_DEPTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // side band that travels with each token: an answer typed in by hand
   logic       pin_on;
   answer_type pin_answer;

   answer_type awaited_answers[$];
   int         mismatch_count;
   int         token_count;
   int         sender_idle_pct;
   int         receiver_idle_pct;
   bit         hold_request;

   // evaluator state as the checker sees it
   logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
   int                stack_fill;
   logic [STAT_W-1:0] held_error;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #RUN_LIMIT_NS;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                input logic [DATA_W-1:0] want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what,
               $signed(got), $signed(want));
      mismatch_count++;
   endtask

   // apply one token to the evaluator state; a last token yields an answer
   function automatic void evaluate_token(input logic [CMD_W-1:0] cmd,
                                          input logic [DATA_W-1:0] num,
                                          input logic last,
                                          output bit produced, output answer_type answer);
      logic [DATA_W-1:0] top_v;
      logic [DATA_W-1:0] second_v;
      logic [DATA_W-1:0] combined;
      longint            quotient;
      produced = 1'b0;
      answer   = '0;
      combined = '0;
      if (held_error == pse_pkg::STAT_OK) begin
         if (cmd == pse_pkg::CMD_PUSH) begin
            if (stack_fill >= STACK_DEPTH) begin
               held_error = pse_pkg::STAT_OVERFLOW;
            end else begin
               stack_mem[stack_fill] = num;
               stack_fill++;
            end
         end else if (cmd <= pse_pkg::CMD_DIV) begin
            if (stack_fill < 2) begin
               held_error = pse_pkg::STAT_UNDERFLOW;
            end else begin
               top_v    = stack_mem[stack_fill-1];
               second_v = stack_mem[stack_fill-2];
               case (cmd)
                  pse_pkg::CMD_ADD: combined = second_v + top_v;
                  pse_pkg::CMD_SUB: combined = second_v - top_v;
                  pse_pkg::CMD_MUL: combined = second_v * top_v;
                  default: begin
                     if (top_v == '0) begin
                        held_error = pse_pkg::STAT_DIVZERO;
                     end else begin
                        quotient = longint'($signed(second_v)) / longint'($signed(top_v));
                        combined = quotient[DATA_W-1:0];
                     end
                  end
               endcase
               if (held_error == pse_pkg::STAT_OK) begin
                  stack_fill--;
                  stack_mem[stack_fill-1] = combined;
               end
            end
         end
      end
      if (last) begin
         produced      = 1'b1;
         answer.status = held_error;
         if (held_error == pse_pkg::STAT_OK) begin
            if (stack_fill == 0)
               answer.status = pse_pkg::STAT_UNDERFLOW;
            else
               answer.value = stack_mem[stack_fill-1];
         end
         stack_fill = 0;
         held_error = pse_pkg::STAT_OK;
      end
   endfunction

   // results first, then the token accepted at the same edge
   always @(posedge clock) begin : scoreboard
      answer_type want;
      answer_type next_answer;
      bit         produced;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_answers.size() == 0) begin
               flag_mismatch("unexpected result value", rsp_bus.value, '0);
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_bus.value !== want.value)
                  flag_mismatch("value", rsp_bus.value, want.value);
               if (rsp_bus.status !== want.status)
                  flag_mismatch("status", DATA_W'(rsp_bus.status), DATA_W'(want.status));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            evaluate_token(req_bus.cmd, req_bus.number, req_bus.last_token,
                           produced, next_answer);
            if (produced)
               awaited_answers.push_back(pin_on ? pin_answer : next_answer);
         end
      end
   end

   // receiver: random ready spans, plus one long hold on request
   initial begin : receiver
      int span;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else begin
            span = $urandom_range(0, 14);
            rsp_bus.ready <= !($urandom_range(0, 99) < receiver_idle_pct);
            repeat (span) @(negedge clock);
         end
      end
   end

   // offer one token and hold it until the transfer, then maybe idle
   task automatic send_token(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] num,
                             input logic last, input logic pinned, input answer_type answer);
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.number     <= num;
      req_bus.last_token <= last;
      pin_on             <= pinned;
      pin_answer         <= answer;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      token_count++;
      @(negedge clock);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
   endtask

   function automatic logic [DATA_W-1:0] pick_operand();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 4))
               0: return INT_MAX;
               1: return INT_MIN;
               2: return MINUS_ONE;
               3: return '0;
               default: return 32'd1;
            endcase
         end
         1, 2: return DATA_W'($signed($urandom_range(0, 20)) - 10);
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 15;
         2: return 40;
         default: return 70;
      endcase
   endfunction

   // well-formed expression over a given number of operands, random content
   task automatic send_expression(input int operands);
      int  depth;
      int  left;
      bit  do_push;
      logic fin;
      depth = 0;
      left  = operands;
      while (left > 0 || depth > 1) begin
         if ($urandom_range(0, 9) == 0)
            send_token(CMD_W'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI)), $urandom,
                       1'b0, 1'b0, '0);
         do_push = (depth < 2) || (left > 0 && $urandom_range(0, 1) == 1);
         if (do_push) begin
            left--;
            depth++;
            fin = (left == 0 && depth == 1);
            send_token(pse_pkg::CMD_PUSH, pick_operand(), fin, 1'b0, '0);
         end else begin
            depth--;
            fin = (left == 0 && depth == 1);
            send_token(CMD_W'($urandom_range(pse_pkg::CMD_ADD, pse_pkg::CMD_DIV)), $urandom,
                       fin, 1'b0, '0);
         end
      end
   endtask

   // pushes from one short of full to two past full, then up to three operators
   task automatic send_deep_stack();
      int pushes;
      int ops;
      pushes = $urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 2);
      ops    = $urandom_range(0, 3);
      repeat (pushes) send_token(pse_pkg::CMD_PUSH, pick_operand(), 1'b0, 1'b0, '0);
      repeat (ops)
         send_token(CMD_W'($urandom_range(pse_pkg::CMD_ADD, pse_pkg::CMD_DIV)), $urandom,
                    1'b0, 1'b0, '0);
      send_token(CMD_W'($urandom_range(0, 7)), pick_operand(), 1'b1, 1'b0, '0);
   endtask

   // unstructured tokens, closed by a last token
   task automatic send_noise();
      repeat ($urandom_range(1, 4))
         send_token(CMD_W'($urandom_range(0, 7)), $urandom, $urandom_range(0, 3) == 0,
                    1'b0, '0);
      send_token(CMD_W'($urandom_range(0, 7)), $urandom, 1'b1, 1'b0, '0);
   endtask

   // stimulus
   initial begin : stimulus
      int  row;
      int  rep;
      int  random_goal;
      int  next_repick;
      int  hold_at;
      bit  hold_done;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = pse_pkg::CMD_PUSH;
      req_bus.number     = '0;
      req_bus.last_token = 1'b0;
      pin_on             = 1'b0;
      pin_answer         = '0;
      stack_fill         = 0;
      held_error         = pse_pkg::STAT_OK;
      mismatch_count     = 0;
      token_count        = 0;
      sender_idle_pct    = 30;
      receiver_idle_pct  = 30;
      hold_request       = 1'b0;
      hold_done          = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (row = 0; row < N_ROWS; row++) begin
         for (rep = 0; rep < DIRECTED_ROWS[row].reps; rep++)
            send_token(DIRECTED_ROWS[row].cmd, DIRECTED_ROWS[row].number,
                       DIRECTED_ROWS[row].last, DIRECTED_ROWS[row].pinned,
                       '{DIRECTED_ROWS[row].value, DIRECTED_ROWS[row].status});
      end

      // random streams, idling re-picked now and then, quiet tail
      random_goal = token_count + RANDOM_TOKENS;
      next_repick = token_count;
      hold_at     = token_count + 150;
      while (token_count < random_goal) begin
         if (token_count >= random_goal - 100) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end else if (token_count >= next_repick) begin
            sender_idle_pct   = pick_idle_pct();
            receiver_idle_pct = pick_idle_pct();
            next_repick       = token_count + 120;
         end
         if (!hold_done && token_count >= hold_at) begin
            hold_request    = 1'b1;
            hold_done       = 1'b1;
            sender_idle_pct = 0;
         end
         case ($urandom_range(0, 9))
            0: send_noise();
            1: send_deep_stack();
            default: send_expression($urandom_range(1,
                        ($urandom_range(0, 7) == 0) ? STACK_DEPTH : 5));
         endcase
      end
      if (req_bus.valid)
         req_bus.valid <= 1'b0;

      // drain
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
